@@ hw/rtl/histeq_pkg.sv @@
// shared types, constants and codes for the histogram equalizer
package histeq_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 1048576;
  localparam int unsigned LEVELS_DEF     = 256;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned REQ_W          = 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MAP   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_BLD_RD,
    ST_BLD_ACC,
    ST_BLD_MUL,
    ST_BLD_DIV,
    ST_BLD_WR,
    ST_MAP_RD,
    ST_MAP_OUT
  } histeq_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture the accepted item
    logic clr_start;   // reset sweep index, total and map flag
    logic clr_step;    // write zero to one bin, advance index
    logic cnt_rd;      // read bin of the captured pixel
    logic cnt_wr;      // write incremented bin, bump total
    logic bld_start;   // reset build index and cdf
    logic bld_rd;      // read bin at build index
    logic bld_acc;     // add bin to cdf
    logic bld_mul;     // form scaled numerator
    logic div_start;   // launch divider
    logic bld_wr;      // write map entry, advance index
    logic map_set;     // map is complete
    logic map_rd;      // read map at captured pixel
    logic out_fire;    // present result
  } histeq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_count;
    logic is_map;
    logic is_last;
    logic has_room;
    logic map_ok;
    logic idx_last;
    logic div_done;
  } histeq_sts_t;

endpackage

@@ hw/rtl/histogram_equalizer.sv @@
// top level of the histogram equalizer
// usage: raise start with an item whenever busy is low; the transfer happens at
// that edge. a clear zeroes one bin per cycle; a map request shows its result in
// the first cycle after busy falls; a count marked last adds a map build in which
// each entry goes through the shared one bit per cycle divider. results show for
// one cycle on out_strobe and cannot be held off. after reset the block stays busy
// while it zeroes the bin store.
module histogram_equalizer #(
  parameter int unsigned MAX_PIXELS = histeq_pkg::MAX_PIXELS_DEF,
  parameter int unsigned LEVELS     = histeq_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [histeq_pkg::REQ_W-1:0] in_req_type,
  input  logic [histeq_pkg::PIX_W-1:0] in_pixel,
  input  logic                         in_last,
  output logic                         out_strobe,
  output logic [histeq_pkg::PIX_W-1:0] out_pixel_out,
  output logic                         out_map_valid
);
  import histeq_pkg::*;

  histeq_cmd_t cmd;
  histeq_sts_t sts;

  // sequencer: one item at a time
  histeq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  // storage and arithmetic
  histeq_dp #(.MAX_PIXELS(MAX_PIXELS), .LEVELS(LEVELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req_type(in_req_type), .in_pixel(in_pixel),
    .in_last(in_last), .cmd(cmd), .sts(sts), .out_pixel_out(out_pixel_out),
    .out_map_valid(out_map_valid), .out_strobe(out_strobe)
  );

`ifndef SYNTH
  // a result always follows a cycle of work on its item
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result without work");
  // a start while idle always makes the block busy next cycle
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer not taken");
  // strobes never come back to back
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("repeated result");
`endif
endmodule

@@ hw/rtl/histeq_ram.sv @@
// generic single-port ram with registered read
module histeq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/histeq_div.sv @@
// restoring divider, one quotient bit per cycle
module histeq_div #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = q_r;
  assign done = done_r;
endmodule

@@ hw/rtl/histeq_dp.sv @@
// datapath: bin ram, map ram, cdf accumulator, scaling and divider
module histeq_dp #(
  parameter int unsigned MAX_PIXELS = 1048576,
  parameter int unsigned LEVELS     = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [histeq_pkg::REQ_W-1:0]   in_req_type,
  input  logic [histeq_pkg::PIX_W-1:0]   in_pixel,
  input  logic                           in_last,
  input  histeq_pkg::histeq_cmd_t        cmd,
  output histeq_pkg::histeq_sts_t        sts,
  output logic [histeq_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                           out_map_valid,
  output logic                           out_strobe
);
  import histeq_pkg::*;

  localparam int unsigned IDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SCL_W  = $clog2(2 * (LEVELS - 1) + 1);
  localparam int unsigned NUM_W  = CNT_W + SCL_W + 1;
  localparam int unsigned DEN_W  = CNT_W + 1;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(LEVELS - 1);

  logic [REQ_W-1:0] req_r;
  logic [PIX_W-1:0] pix_r;
  logic             last_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] cdf_r;
  logic [NUM_W-1:0] num_r;
  logic             map_ok_r;
  logic [PIX_W-1:0] res_pix_r;
  logic             res_ok_r, strobe_r;
  logic [IDX_W-1:0] lvl;

  logic             bin_we;
  logic [IDX_W-1:0] bin_addr;
  logic [CNT_W-1:0] bin_wdata, bin_rdata;
  logic             map_we;
  logic [IDX_W-1:0] map_addr;
  logic [PIX_W-1:0] map_wdata, map_rdata;
  logic [NUM_W-1:0] quo;
  logic             div_done;

  // saturate the pixel to the top level
  assign lvl = ({1'b0, pix_r} >= (PIX_W + 1)'(LEVELS)) ? TOP_IDX : IDX_W'(pix_r);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clr_start || cmd.bld_start) begin
      idx_nxt = '0;
    end else if (cmd.clr_step || cmd.bld_wr) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    bin_we    = 1'b0;
    bin_wdata = bin_rdata + 1'b1;
    bin_addr  = idx_r;
    if (cmd.clr_step) begin
      bin_we    = 1'b1;
      bin_wdata = '0;
    end else if (cmd.cnt_rd || cmd.cnt_wr) begin
      bin_addr = lvl;
      bin_we   = cmd.cnt_wr;
    end
  end

  always_comb begin
    map_addr  = cmd.map_rd ? lvl : idx_r;
    map_we    = cmd.bld_wr;
    map_wdata = (quo > NUM_W'(LEVELS - 1)) ? PIX_W'(LEVELS - 1) : PIX_W'(quo);
  end

  histeq_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_bins (
    .clk(clk), .we(bin_we), .addr(bin_addr), .wdata(bin_wdata), .rdata(bin_rdata)
  );

  histeq_ram #(.WIDTH(PIX_W), .DEPTH(LEVELS)) u_map (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rdata)
  );

  histeq_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(num_r),
    .den({total_r, 1'b0}), .quo(quo), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      map_ok_r <= 1'b0;
      strobe_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (cmd.clr_start) begin
        total_r  <= '0;
        map_ok_r <= 1'b0;
      end else if (cmd.cnt_wr) begin
        total_r <= total_r + 1'b1;
      end
      if (cmd.map_set) begin
        map_ok_r <= 1'b1;
      end
      strobe_r <= cmd.out_fire;
      idx_r    <= idx_nxt;
    end
    if (cmd.load_in) begin
      req_r  <= in_req_type;
      pix_r  <= in_pixel;
      last_r <= in_last;
    end
    if (cmd.bld_start) begin
      cdf_r <= '0;
    end else if (cmd.bld_acc) begin
      cdf_r <= cdf_r + bin_rdata;
    end
    if (cmd.bld_mul) begin
      num_r <= NUM_W'(cdf_r) * NUM_W'(2 * (LEVELS - 1)) + NUM_W'(total_r);
    end
    if (cmd.out_fire) begin
      res_pix_r <= map_ok_r ? map_rdata : pix_r;
      res_ok_r  <= map_ok_r;
    end
  end

  assign sts.is_clear = (req_r == REQ_CLEAR);
  assign sts.is_count = (req_r == REQ_COUNT);
  assign sts.is_map   = (req_r == REQ_MAP);
  assign sts.is_last  = last_r;
  assign sts.has_room = (total_r < CNT_W'(MAX_PIXELS));
  assign sts.map_ok   = map_ok_r;
  assign sts.idx_last = (idx_r == TOP_IDX);
  assign sts.div_done = div_done;

  assign out_pixel_out = res_pix_r;
  assign out_map_valid = res_ok_r;
  assign out_strobe    = strobe_r;
endmodule

@@ hw/rtl/histeq_ctrl.sv @@
// controller state machine
module histeq_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  histeq_pkg::histeq_sts_t sts,
  output histeq_pkg::histeq_cmd_t cmd,
  output logic                    busy
);
  import histeq_pkg::*;

  histeq_state_t state_r, state_nxt;

  // reset starts with a sweep that zeroes every bin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        // decode the captured request
        if (sts.is_clear) begin
          cmd.clr_start = 1'b1;
          state_nxt     = ST_CLR;
        end else if (sts.is_count) begin
          cmd.cnt_rd = 1'b1;
          state_nxt  = ST_CNT_WR;
        end else if (sts.is_map) begin
          cmd.map_rd = 1'b1;
          state_nxt  = ST_MAP_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CNT_WR: begin
        cmd.cnt_wr = sts.has_room;
        if (sts.is_last) begin
          cmd.bld_start = 1'b1;
          state_nxt     = ST_BLD_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BLD_RD: begin
        cmd.bld_rd = 1'b1;
        state_nxt  = ST_BLD_ACC;
      end
      ST_BLD_ACC: begin
        cmd.bld_acc = 1'b1;
        state_nxt   = ST_BLD_MUL;
      end
      ST_BLD_MUL: begin
        cmd.bld_mul = 1'b1;
        state_nxt   = ST_BLD_DIV;
      end
      ST_BLD_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        if (sts.div_done) begin
          cmd.bld_wr = 1'b1;
          if (sts.idx_last) begin
            cmd.map_set = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            state_nxt = ST_BLD_RD;
          end
        end
      end
      ST_MAP_RD: begin
        cmd.map_rd = 1'b1;
        state_nxt  = ST_MAP_OUT;
      end
      ST_MAP_OUT: begin
        cmd.out_fire = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

@@ tb/tb_histogram_equalizer.sv @@
// testbench for the histogram equalizer: directed table, then random frames
module tb_histogram_equalizer;
  import histeq_pkg::*;

  // unused request code, the block must ignore it
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
  localparam int ITEM_GOAL = 1900;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             valid;
  } eq_result_t;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             typed;   // expected result typed in below
    logic [PIX_W-1:0] exp_pix;
    logic             exp_valid;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [REQ_W-1:0] in_req_type;
  logic [PIX_W-1:0] in_pixel;
  logic             in_last;
  logic             out_strobe;
  logic [PIX_W-1:0] out_pixel_out;
  logic             out_map_valid;

  // typed expectation travels with the item it belongs to
  logic             row_typed;
  logic [PIX_W-1:0] row_exp_pix;
  logic             row_exp_valid;

  // predictor state
  int unsigned      hist_bins [LEVELS_DEF];
  int unsigned      pix_seen;
  logic [PIX_W-1:0] eq_lut [LEVELS_DEF];
  logic             lut_live;

  eq_result_t       pending_q[$];
  int               errors;
  int               items_sent;

  histogram_equalizer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_pixel     (in_pixel),
    .in_last      (in_last),
    .out_strobe   (out_strobe),
    .out_pixel_out(out_pixel_out),
    .out_map_valid(out_map_valid)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned level_of(logic [PIX_W-1:0] p);
    return (p >= LEVELS_DEF) ? LEVELS_DEF - 1 : p;
  endfunction

  // rebuild the lookup table: round(cdf * (levels-1) / n), ties up
  function automatic void rebuild_lut();
    longint unsigned cdf;
    longint unsigned n;
    longint unsigned v;
    cdf = 0;
    n = pix_seen;
    for (int i = 0; i < LEVELS_DEF; i++) begin
      cdf += hist_bins[i];
      v = 0;
      if (n != 0) begin
        v = (2 * (LEVELS_DEF - 1) * cdf + n) / (2 * n);
        if (v > LEVELS_DEF - 1) v = LEVELS_DEF - 1;
      end
      eq_lut[i] = v[PIX_W-1:0];
    end
    lut_live = 1'b1;
  endfunction

  // advance the predictor by one accepted item; returns 1 with a result
  function automatic bit equalize_item(input logic [REQ_W-1:0] req, input logic [PIX_W-1:0] pix,
                                       input logic last, output eq_result_t res);
    res.pix = '0;
    res.valid = 1'b0;
    case (req)
      REQ_CLEAR: begin
        foreach (hist_bins[i]) hist_bins[i] = 0;
        pix_seen = 0;
        lut_live = 1'b0;
        return 0;
      end
      REQ_COUNT: begin
        // capacity reached: bins frozen, last still builds
        if (pix_seen < MAX_PIXELS_DEF) begin
          hist_bins[level_of(pix)]++;
          pix_seen++;
        end
        if (last) rebuild_lut();
        return 0;
      end
      REQ_MAP: begin
        if (lut_live) begin
          res.pix = eq_lut[level_of(pix)];
          res.valid = 1'b1;
        end else begin
          // no map yet: pixel passes through unflagged
          res.pix = pix;
          res.valid = 1'b0;
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // acceptance and result checking, both on the rising edge
  always @(posedge clk) begin
    eq_result_t res;
    eq_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual pix %0d valid %0d",
                   $time, out_pixel_out, out_map_valid);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (out_pixel_out !== want.pix) begin
            $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                     $time, want.pix, out_pixel_out);
            errors++;
          end
          if (out_map_valid !== want.valid) begin
            $display("%0t: map_valid mismatch: expected %0d, actual %0d",
                     $time, want.valid, out_map_valid);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (equalize_item(in_req_type, in_pixel, in_last, res)) begin
          if (row_typed) begin
            res.pix = row_exp_pix;
            res.valid = row_exp_valid;
          end
          pending_q.push_back(res);
        end
      end
    end
  end

  // one transfer: random gap, then hold start until the block takes it
  task automatic send(input logic [REQ_W-1:0] req, input logic [PIX_W-1:0] pix,
                      input logic last, input logic typed = 1'b0,
                      input logic [PIX_W-1:0] e_pix = '0, input logic e_valid = 1'b0);
    int gap;
    gap = $urandom_range(0, 5);
    // stretches with no idling at all
    if ($urandom_range(0, 7) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_pixel <= pix;
    in_last <= last;
    row_typed <= typed;
    row_exp_pix <= e_pix;
    row_exp_valid <= e_valid;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // one edge first so the last accepted item is already queued
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // one random frame: clear, skewed counts closed by last, then map reads with stray unused codes
  task automatic random_frame();
    int n;
    int lo;
    int hi;
    int m;
    send(REQ_CLEAR, PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      send(REQ_MAP, PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
    lo = $urandom_range(0, 255);
    hi = $urandom_range(lo, 255);
    if ($urandom_range(0, 3) == 0) begin
      lo = 0;
      hi = 255;
    end
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 30) == 0) send(REQ_NONE, PIX_W'($urandom_range(0, 255)), 1'b0);
      send(REQ_COUNT, PIX_W'($urandom_range(lo, hi)), k == n - 1);
    end
    m = $urandom_range(20, 60);
    for (int k = 0; k < m; k++) begin
      if ($urandom_range(0, 15) == 0)
        send(REQ_NONE, PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        send(REQ_MAP, PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      // counting on after a build keeps the old map until the next last
      if (k == m / 2 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) send(REQ_COUNT, PIX_W'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 1)) send(REQ_COUNT, PIX_W'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  stim_row_t stim_table[] = '{
    // before any clear: passthrough, unflagged
    '{REQ_MAP,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
    '{REQ_MAP,   8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
    '{REQ_CLEAR, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{REQ_COUNT, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{REQ_COUNT, 8'd128, 1'b1, 1'b0, 8'd0,   1'b0},
    // three pixels: levels 85, 170 and 255
    '{REQ_MAP,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{REQ_MAP,   8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
    '{REQ_MAP,   8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
    '{REQ_MAP,   8'd7,   1'b1, 1'b0, 8'd0,   1'b0},
    // unused code: ignored even with last set
    '{REQ_NONE,  8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
    // count after build without clear: old map stays
    '{REQ_COUNT, 8'd77,  1'b0, 1'b0, 8'd0,   1'b0},
    '{REQ_MAP,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{REQ_COUNT, 8'd200, 1'b1, 1'b0, 8'd0,   1'b0},
    '{REQ_MAP,   8'd200, 1'b0, 1'b0, 8'd0,   1'b0},
    '{REQ_MAP,   8'd100, 1'b0, 1'b0, 8'd0,   1'b0},
    // clear withdraws the map
    '{REQ_CLEAR, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
    '{REQ_MAP,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
    // single pixel frame: a step from 0 to 255
    '{REQ_COUNT, 8'd9,   1'b1, 1'b0, 8'd0,   1'b0},
    '{REQ_MAP,   8'd8,   1'b0, 1'b1, 8'd0,   1'b1},
    '{REQ_MAP,   8'd9,   1'b0, 1'b1, 8'd255, 1'b1},
    '{REQ_MAP,   8'd255, 1'b1, 1'b0, 8'd0,   1'b0}
  };

  initial begin
    errors = 0;
    items_sent = 0;
    lut_live = 1'b0;
    pix_seen = 0;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    foreach (eq_lut[i]) eq_lut[i] = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_CLEAR;
    in_pixel = '0;
    in_last = 1'b0;
    row_typed = 1'b0;
    row_exp_pix = '0;
    row_exp_valid = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i])
      send(stim_table[i].req, stim_table[i].pix, stim_table[i].last, stim_table[i].typed,
           stim_table[i].exp_pix, stim_table[i].exp_valid);

    // sender holds off until every result is back
    drain();

    while (items_sent < ITEM_GOAL) begin
      random_frame();
      if ($urandom_range(0, 5) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, well above the slowest legal run
  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/histeq_pkg.sv
hw/rtl/histeq_ram.sv
hw/rtl/histeq_div.sv
hw/rtl/histeq_dp.sv
hw/rtl/histeq_ctrl.sv
hw/rtl/histogram_equalizer.sv
tb/tb_histogram_equalizer.sv
